>>> hw/rtl/plane_rect_attractor_force_macros.svh
// Assertion macros used by the checker file.
`ifndef PLANE_RECT_ATTRACTOR_FORCE_MACROS_SVH
`define PLANE_RECT_ATTRACTOR_FORCE_MACROS_SVH

// same-cycle implication, off during reset
`define PRAC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define PRAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, active during reset
`define PRAC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/prac_pkg.sv
// Shared constants and types of the plane rectangle attractor pipeline.
package prac_pkg;

  localparam int SQRT_STEPS = 33;
  localparam int RAD_W      = 66;
  localparam int ROOT_W     = 33;
  localparam int REM_W      = 36;

  localparam int DIV_STEPS  = 31;
  localparam int NUM_W      = 63;
  localparam int DEN_W      = 64;

  localparam int LAT = 4 + SQRT_STEPS + 1 + DIV_STEPS + 2 + DIV_STEPS + 1;

  typedef enum logic [2:0] {
    REG_STRENGTH = 3'd0,
    REG_LEFT     = 3'd1,
    REG_TOP      = 3'd2,
    REG_RIGHT    = 3'd3,
    REG_BOTTOM   = 3'd4,
    REG_LIFE     = 3'd5,
    REG_MIN_DIST = 3'd6,
    REG_CAP      = 3'd7
  } reg_idx_t;

  localparam logic [30:0] RST_STRENGTH = 31'd327680;
  localparam logic [31:0] RST_LEFT     = 32'hFFFF_0000;
  localparam logic [31:0] RST_TOP      = 32'h0001_0000;
  localparam logic [31:0] RST_RIGHT    = 32'h0001_0000;
  localparam logic [31:0] RST_BOTTOM   = 32'hFFFF_0000;
  localparam logic [30:0] RST_LIFE     = 31'd22937600;
  localparam logic [30:0] RST_MIN_DIST = 31'd3277;
  localparam logic [30:0] RST_CAP      = 31'd3276800;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic [31:0]        mx;
    logic [31:0]        my;
    logic [31:0]        mz;
    logic               nx;
    logic               ny;
    logic               nz;
    logic               old;
    logic               skip;
    logic               big;
    logic               capsel;
    logic [ROOT_W-1:0]  dlen;
  } side_t;

endpackage

>>> hw/rtl/plane_rect_attractor_force.sv
// Throughput: one particle per cycle; the whole pipeline advances together and
// freezes only while a result waits at the output under stall.
// Depth is set by the 33-step square root and two 31-step dividers.
// Reset (synchronous, rst high) clears all valid bits and loads register defaults.
module plane_rect_attractor_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [30:0]        lifetime,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] new_force_x,
  output logic signed [31:0] new_force_y,
  output logic signed [31:0] new_force_z,
  output logic               applied
);
  import prac_pkg::*;

  logic [30:0]        strength;
  logic signed [31:0] left_edge;
  logic signed [31:0] top_edge;
  logic signed [31:0] right_edge;
  logic signed [31:0] bottom_edge;
  logic [30:0]        lifetime_limit;
  logic [30:0]        min_distance;
  logic [30:0]        force_cap;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      strength       <= RST_STRENGTH;
      left_edge      <= RST_LEFT;
      top_edge       <= RST_TOP;
      right_edge     <= RST_RIGHT;
      bottom_edge    <= RST_BOTTOM;
      lifetime_limit <= RST_LIFE;
      min_distance   <= RST_MIN_DIST;
      force_cap      <= RST_CAP;
    end else if (wr) begin
      unique case (idx)
        REG_STRENGTH: strength       <= pwdata[30:0];
        REG_LEFT:     left_edge      <= pwdata;
        REG_TOP:      top_edge       <= pwdata;
        REG_RIGHT:    right_edge     <= pwdata;
        REG_BOTTOM:   bottom_edge    <= pwdata;
        REG_LIFE:     lifetime_limit <= pwdata[30:0];
        REG_MIN_DIST: min_distance   <= pwdata[30:0];
        REG_CAP:      force_cap      <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STRENGTH: prdata = {1'b0, strength};
      REG_LEFT:     prdata = left_edge;
      REG_TOP:      prdata = top_edge;
      REG_RIGHT:    prdata = right_edge;
      REG_BOTTOM:   prdata = bottom_edge;
      REG_LIFE:     prdata = {1'b0, lifetime_limit};
      REG_MIN_DIST: prdata = {1'b0, min_distance};
      REG_CAP:      prdata = {1'b0, force_cap};
      default:      prdata = '0;
    endcase
  end

  // pipeline control
  logic           en;
  logic [LAT-1:0] vld;

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage 1: input capture
  logic signed [31:0] px, py, pz;
  logic [30:0]        life;
  logic signed [31:0] fx1, fy1, fz1;

  always_ff @(posedge clk) begin
    if (en) begin
      px   <= pos_x;
      py   <= pos_y;
      pz   <= pos_z;
      life <= lifetime;
      fx1  <= force_x;
      fy1  <= force_y;
      fz1  <= force_z;
    end
  end

  // stage 2: clamp and offset
  logic signed [31:0] cx, cy;
  logic signed [32:0] dx, dy, dz;
  logic [32:0]        ax, ay, az;
  side_t              s2_next, s2;

  always_comb begin
    if (px < left_edge)       cx = left_edge;
    else if (px > right_edge) cx = right_edge;
    else                      cx = px;
    if (py > top_edge)         cy = top_edge;
    else if (py < bottom_edge) cy = bottom_edge;
    else                       cy = py;
    dx = {cx[31], cx} - {px[31], px};
    dy = {cy[31], cy} - {py[31], py};
    dz = 33'sd0 - {pz[31], pz};
    ax = dx[32] ? -dx : dx;
    ay = dy[32] ? -dy : dy;
    az = dz[32] ? -dz : dz;
    s2_next        = '0;
    s2_next.fx     = fx1;
    s2_next.fy     = fy1;
    s2_next.fz     = fz1;
    s2_next.mx     = ax[31:0];
    s2_next.my     = ay[31:0];
    s2_next.mz     = az[31:0];
    s2_next.nx     = dx[32];
    s2_next.ny     = dy[32];
    s2_next.nz     = dz[32];
    s2_next.old    = (life > lifetime_limit);
  end

  always_ff @(posedge clk) begin
    if (en) s2 <= s2_next;
  end

  // stage 3: squares
  logic [63:0] sqx, sqy, sqz;
  side_t       s3;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= s2.mx * s2.mx;
      sqy <= s2.my * s2.my;
      sqz <= s2.mz * s2.mz;
      s3  <= s2;
    end
  end

  // stage 4: sum of squares
  logic [RAD_W-1:0] sum;
  side_t            s4;

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
      s4  <= s3;
    end
  end

  // square root
  logic [ROOT_W-1:0] root;
  side_t             dl1 [SQRT_STEPS];

  prac_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl1[0] <= s4;
      for (int k = 1; k < SQRT_STEPS; k++) dl1[k] <= dl1[k-1];
    end
  end

  // distance checks and distance squared
  side_t       s5_next, s5, s5c;
  logic [63:0] d2;

  always_comb begin
    s5_next      = dl1[SQRT_STEPS-1];
    s5_next.dlen = root;
    s5_next.big  = root[ROOT_W-1];
    s5_next.skip = s5_next.old || (root == '0) || (root < {2'b00, min_distance});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5 <= s5_next;
      d2 <= s5_next.dlen[31:0] * s5_next.dlen[31:0];
    end
  end

  // quotient of strength by distance squared; capped when it reaches 2^31
  logic [DIV_STEPS-1:0] mq;
  side_t                dl2 [DIV_STEPS];

  always_comb begin
    s5c        = s5;
    s5c.capsel = ({32'b0, strength, 1'b0} >= d2);
  end

  prac_div u_div_mag (
    .clk (clk),
    .en  (en),
    .num ({strength, 32'b0}),
    .den (d2),
    .quo (mq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl2[0] <= s5c;
      for (int k = 1; k < DIV_STEPS; k++) dl2[k] <= dl2[k-1];
    end
  end

  // magnitude select
  logic [30:0] mag;
  side_t       s6, s6l;

  assign s6l = dl2[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (s6l.big)          mag <= '0;
      else if (s6l.capsel)  mag <= force_cap;
      else if (mq > force_cap) mag <= force_cap;
      else                  mag <= mq;
      s6 <= s6l;
    end
  end

  // component products
  logic [NUM_W-1:0] prx, pry, prz;
  side_t            s7;

  always_ff @(posedge clk) begin
    if (en) begin
      prx <= {32'b0, mag} * {31'b0, s6.mx};
      pry <= {32'b0, mag} * {31'b0, s6.my};
      prz <= {32'b0, mag} * {31'b0, s6.mz};
      s7  <= s6;
    end
  end

  // component quotients
  logic [DIV_STEPS-1:0] qx, qy, qz;
  logic [DEN_W-1:0]     dden;
  side_t                dl3 [DIV_STEPS];

  assign dden = {{(DEN_W-ROOT_W){1'b0}}, s7.dlen};

  prac_div u_div_x (.clk(clk), .en(en), .num(prx), .den(dden), .quo(qx));
  prac_div u_div_y (.clk(clk), .en(en), .num(pry), .den(dden), .quo(qy));
  prac_div u_div_z (.clk(clk), .en(en), .num(prz), .den(dden), .quo(qz));

  always_ff @(posedge clk) begin
    if (en) begin
      dl3[0] <= s7;
      for (int k = 1; k < DIV_STEPS; k++) dl3[k] <= dl3[k-1];
    end
  end

  // saturating accumulate, output register
  function automatic logic [31:0] sat_add(input logic [31:0] f, input logic [30:0] q,
                                          input logic neg);
    logic [32:0] a;
    logic [32:0] s;
    a = {f[31], f};
    s = neg ? (a - {2'b00, q}) : (a + {2'b00, q});
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

  side_t sf;
  assign sf = dl3[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (sf.skip) begin
        new_force_x <= sf.fx;
        new_force_y <= sf.fy;
        new_force_z <= sf.fz;
        applied     <= 1'b0;
      end else begin
        new_force_x <= sat_add(sf.fx, sf.big ? '0 : qx, sf.nx);
        new_force_y <= sat_add(sf.fy, sf.big ? '0 : qy, sf.ny);
        new_force_z <= sat_add(sf.fz, sf.big ? '0 : qz, sf.nz);
        applied     <= 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/prac_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module prac_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [prac_pkg::RAD_W-1:0]    rad,
  output logic [prac_pkg::ROOT_W-1:0]   root
);
  import prac_pkg::*;

  logic [REM_W-1:0]  rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];
  logic [RAD_W-1:0]  rad_q  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    logic [REM_W-1:0]  r_in;
    logic [ROOT_W-1:0] q_in;
    logic [RAD_W-1:0]  a_in;
    logic [REM_W-1:0]  t;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign a_in = rad;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign q_in = root_q[k-1];
      assign a_in = rad_q[k-1];
    end

    assign t     = {r_in[REM_W-3:0], a_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, q_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= trial) begin
          rem_q[k]  <= t - trial;
          root_q[k] <= {q_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= t;
          root_q[k] <= {q_in[ROOT_W-2:0], 1'b0};
        end
        rad_q[k] <= {a_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[SQRT_STEPS-1];

endmodule

>>> hw/rtl/prac_div.sv
// Pipelined restoring divider, quotient bounded below 2^31, one bit per stage.
module prac_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [prac_pkg::NUM_W-1:0]        num,
  input  logic [prac_pkg::DEN_W-1:0]        den,
  output logic [prac_pkg::DIV_STEPS-1:0]    quo
);
  import prac_pkg::*;

  logic [DEN_W-1:0]     r_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] n_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_q [DIV_STEPS];
  logic [DEN_W-1:0]     d_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    logic [DEN_W-1:0]     r_in;
    logic [DIV_STEPS-1:0] n_in;
    logic [DIV_STEPS-1:0] q_in;
    logic [DEN_W-1:0]     d_in;
    logic [DEN_W:0]       t;
    logic [DEN_W:0]       diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign r_in = {{(DEN_W-(NUM_W-DIV_STEPS)){1'b0}}, num[NUM_W-1:DIV_STEPS]};
      assign n_in = num[DIV_STEPS-1:0];
      assign q_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign n_in = n_q[k-1];
      assign q_in = q_q[k-1];
      assign d_in = d_q[k-1];
    end

    assign t    = {r_in, n_in[DIV_STEPS-1]};
    assign diff = t - {1'b0, d_in};
    assign ge   = (t >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        q_q[k] <= {q_in[DIV_STEPS-2:0], ge};
        n_q[k] <= {n_in[DIV_STEPS-2:0], 1'b0};
        d_q[k] <= d_in;
      end
    end
  end

  assign quo = q_q[DIV_STEPS-1];

endmodule

>>> hw/rtl/prac_checker.sv
// Port-level checker for the attractor pipeline, bound to the top level.
`include "plane_rect_attractor_force_macros.svh"

module prac_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] new_force_x,
  input logic signed [31:0] new_force_y,
  input logic signed [31:0] new_force_z,
  input logic               applied
);
  import prac_pkg::*;

  logic [96:0] out_word;

  assign out_word = {new_force_x, new_force_y, new_force_z, applied};

  `PRAC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `PRAC_ASSERT_NOW(a_stall_link, 1'b1, in_stall == (out_valid && out_stall))
  `PRAC_ASSERT_RST(a_rst_empty, rst, !out_valid)

endmodule

bind plane_rect_attractor_force prac_checker u_prac_checker (.*);
